[design/bipl_pkg.sv]
// ----------------------------------------------------------------------------
// bipl_pkg
// shared constants, codes and types of the brace index list parser
// ----------------------------------------------------------------------------
package bipl_pkg;

   localparam int VALUE_BITS_DEF = 31;   // accumulator width
   localparam int OUT_VALUE_W    = 31;   // width of the value field of a result
   localparam int CHAR_W         = 8;
   localparam int ERR_W          = 4;

   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE        = 4'd0,
      ERR_NO_OPEN     = 4'd1,
      ERR_BAD_CHAR    = 4'd2,
      ERR_NO_COMMA    = 4'd3,
      ERR_STAR_IN_NUM = 4'd4,
      ERR_EMPTY_SLOT  = 4'd5,
      ERR_BRACE_EARLY = 4'd6,
      ERR_NO_CLOSE    = 4'd7,
      ERR_OVERFLOW    = 4'd8
   } error_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              last_char;
   } item_type;

   typedef struct packed {
      logic                   value_valid;
      logic [OUT_VALUE_W-1:0] value;
      logic                   wildcard_res;
      logic                   done_res;
      logic [ERR_W-1:0]       error;
   } result_type;

endpackage

[design/bipl_if.sv]
// ----------------------------------------------------------------------------
// bipl_if
// valid/ready channels for character words and result words
// ----------------------------------------------------------------------------
interface bipl_req_if
   import bipl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface bipl_rsp_if
   import bipl_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   value_valid;
   logic [OUT_VALUE_W-1:0] value;
   logic                   wildcard_res;
   logic                   done_res;
   logic [ERR_W-1:0]       error;

   modport source (output valid, output value_valid, output value, output wildcard_res,
                   output done_res, output error, input ready);
   modport sink   (input valid, input value_valid, input value, input wildcard_res,
                   input done_res, input error, output ready);
endinterface

[design/bipl_core.sv]
// ----------------------------------------------------------------------------
// bipl_core
// parser state and per-character decode, one character word per cycle while fire is high
// ----------------------------------------------------------------------------
module bipl_core
   import bipl_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic                  at_start_ff, at_start_in;
   logic                  in_number_ff, in_number_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  slot_ff, slot_in;
   error_type             err_ff, err_in;

   logic [VALUE_BITS+3:0]  acc_next;
   logic [OUT_VALUE_W-1:0] acc_out;
   logic                   is_digit;
   logic                   emit_num;
   logic                   emit_wild;
   error_type              new_err;
   error_type              err_final;

   assign is_digit = (item.char_in inside {[CH_ZERO:CH_NINE]});
   // ten times the accumulator plus the digit, wide enough to see overflow
   assign acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {{VALUE_BITS{1'b0}}, item.char_in[3:0]};

   generate
      if (VALUE_BITS >= OUT_VALUE_W) begin : g_trunc
         assign acc_out = acc_ff[OUT_VALUE_W-1:0];
      end else begin : g_ext
         assign acc_out = {{(OUT_VALUE_W-VALUE_BITS){1'b0}}, acc_ff};
      end
   endgenerate

   always_comb begin
      at_start_in  = at_start_ff;
      in_number_in = in_number_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      err_in       = err_ff;
      new_err      = ERR_NONE;
      emit_num     = 1'b0;
      emit_wild    = 1'b0;

      if (err_ff == ERR_NONE) begin
         if (at_start_ff) begin
            at_start_in = 1'b0;
            if (item.char_in != CH_LBRACE) begin
               new_err = ERR_NO_OPEN;
            end
         end else if (is_digit) begin
            if (slot_ff) begin
               new_err = ERR_NO_COMMA;
            end else if (acc_next[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
               new_err = ERR_OVERFLOW;
            end else begin
               acc_in       = acc_next[VALUE_BITS-1:0];
               in_number_in = 1'b1;
            end
         end else begin
            case (item.char_in)
               CH_STAR: begin
                  if (slot_ff) begin
                     new_err = ERR_NO_COMMA;
                  end else if (in_number_ff) begin
                     new_err = ERR_STAR_IN_NUM;
                  end else begin
                     emit_wild = 1'b1;
                     slot_in   = 1'b1;
                  end
               end
               CH_SPACE: begin
                  emit_num = in_number_ff;
               end
               CH_COMMA: begin
                  emit_num = in_number_ff;
                  if (!(slot_ff || in_number_ff)) begin
                     new_err = ERR_EMPTY_SLOT;
                  end
               end
               CH_RBRACE: begin
                  emit_num = in_number_ff;
                  if (!item.last_char) begin
                     new_err = ERR_BRACE_EARLY;
                  end
               end
               default: begin
                  new_err = ERR_BAD_CHAR;
               end
            endcase
            if (emit_num) begin
               acc_in       = '0;
               in_number_in = 1'b0;
               slot_in      = 1'b1;
            end
            // a comma that is accepted opens a fresh slot
            if (item.char_in == CH_COMMA) begin
               slot_in = 1'b0;
            end
         end

         if (new_err == ERR_NONE && item.last_char && item.char_in != CH_RBRACE) begin
            new_err = ERR_NO_CLOSE;
         end
         if (new_err != ERR_NONE) begin
            err_in    = new_err;
            emit_num  = 1'b0;
            emit_wild = 1'b0;
         end
      end else begin
         at_start_in = 1'b0;
      end

      err_final = err_in;

      // end of string puts everything back to the reset state
      if (item.last_char) begin
         at_start_in  = 1'b1;
         in_number_in = 1'b0;
         acc_in       = '0;
         slot_in      = 1'b0;
         err_in       = ERR_NONE;
      end

      result.value_valid  = emit_num || emit_wild;
      result.value        = emit_num ? acc_out : '0;
      result.wildcard_res = emit_wild;
      result.done_res     = item.last_char;
      result.error        = item.last_char ? err_final : ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff  <= 1'b1;
         in_number_ff <= 1'b0;
         acc_ff       <= '0;
         slot_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
      end else if (fire) begin
         at_start_ff  <= at_start_in;
         in_number_ff <= in_number_in;
         acc_ff       <= acc_in;
         slot_ff      <= slot_in;
         err_ff       <= err_in;
      end
   end

   // a finished string leaves the parser clean
   a_clean_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_char |=> at_start_ff && err_ff == ERR_NONE && !in_number_ff)
      else $error("parser state not cleared after last word");

   // first error of a string is kept until its end
   a_sticky_error: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_NONE && !(fire && item.last_char) |=> err_ff == $past(err_ff))
      else $error("sticky error changed inside a string");

   // no number may be under way while an element is held in the slot
   a_slot_vs_number: assert property (@(posedge clock) disable iff (reset)
      err_ff == ERR_NONE |-> !(slot_ff && in_number_ff))
      else $error("number accumulating in a filled slot");

endmodule

[design/brace_index_list_parser_unit.sv]
// a word is registered in item_ff on acceptance and its result word is registered
// in out_ff when the word is processed, which a stalled result side can hold back
// throughput: one character word per cycle while the result side is not stalled
// reset: synchronous, active high; both stages empty, parser waits for an open brace
// ----------------------------------------------------------------------------
// brace_index_list_parser_unit
// parses brace index lists such as {12, *, 7} one character word at a time
// ----------------------------------------------------------------------------
module brace_index_list_parser_unit
   import bipl_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bipl_req_if.sink    req_chan,
   bipl_rsp_if.source  rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type core_result;
   logic       advance;
   logic       fire;
   logic       req_fire;

   assign advance          = !out_valid_ff || rsp_chan.ready;
   assign fire             = in_valid_ff && advance;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_fire         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.char_in   <= req_chan.char_in;
         item_ff.last_char <= req_chan.last_char;
      end
      if (fire) begin
         out_ff <= core_result;
      end
   end

   bipl_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .result (core_result)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.value_valid  = out_ff.value_valid;
   assign rsp_chan.value        = out_ff.value;
   assign rsp_chan.wildcard_res = out_ff.wildcard_res;
   assign rsp_chan.done_res     = out_ff.done_res;
   assign rsp_chan.error        = out_ff.error;

   a_wild_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.wildcard_res |-> out_ff.value == '0 && out_ff.value_valid)
      else $error("wildcard word with nonzero value");

   a_error_only_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.error != ERR_NONE |-> out_ff.done_res && !out_ff.value_valid)
      else $error("error reported off the last word or with an element");

   a_result_follows_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed word produced no result word");

endmodule

[tb/brace_index_list_parser_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brace_index_list_parser_unit_tb
// drives character words into the parser and checks every result word
// against a local parser model. Covers each error code, value extremes,
// random well-formed lists with mutations, a long output stall and a
// stretch at full rate with no idling
// ----------------------------------------------------------------------------
module brace_index_list_parser_unit_tb;
   import bipl_pkg::*;

   localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS_DEF) - 1;
   localparam longint unsigned RADIX       = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bipl_req_if req_if ();
   bipl_rsp_if rsp_if ();

   brace_index_list_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // model state of the parser
   logic            mdl_at_start    = 1'b1;
   logic            mdl_in_number   = 1'b0;
   longint unsigned mdl_acc         = 0;
   logic            mdl_slot_filled = 1'b0;
   error_type       mdl_err         = ERR_NONE;

   result_type        due_results[$];
   logic [CHAR_W-1:0] line_buf[$];
   int                chars_sent     = 0;
   int                mismatch_count = 0;
   bit                idling         = 1'b1;
   int                rsp_hold_req   = 0;
   int                rsp_wait_left  = 0;

   // one character through the model, returns the result word it causes
   function automatic result_type parse_char(input logic [CHAR_W-1:0] c, input logic last);
      result_type      r;
      error_type       new_err;
      longint unsigned digit;
      r       = '0;
      new_err = ERR_NONE;
      if (mdl_err == ERR_NONE) begin
         if (mdl_at_start) begin
            mdl_at_start = 1'b0;
            if (c != CH_LBRACE) new_err = ERR_NO_OPEN;
         end else begin
            // space, comma and closing brace all finish a pending number first
            if ((c == CH_SPACE || c == CH_COMMA || c == CH_RBRACE) && mdl_in_number) begin
               r.value_valid   = 1'b1;
               r.value         = mdl_acc[OUT_VALUE_W-1:0];
               mdl_acc         = 0;
               mdl_in_number   = 1'b0;
               mdl_slot_filled = 1'b1;
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
               digit = c - CH_ZERO;
               if (mdl_slot_filled) begin
                  new_err = ERR_NO_COMMA;
               end else if (mdl_acc > (VALUE_LIMIT - digit) / RADIX) begin
                  new_err = ERR_OVERFLOW;
               end else begin
                  mdl_acc       = mdl_acc * RADIX + digit;
                  mdl_in_number = 1'b1;
               end
            end else if (c == CH_STAR) begin
               if (mdl_slot_filled) begin
                  new_err = ERR_NO_COMMA;
               end else if (mdl_in_number) begin
                  new_err = ERR_STAR_IN_NUM;
               end else begin
                  r.value_valid   = 1'b1;
                  r.wildcard_res  = 1'b1;
                  mdl_slot_filled = 1'b1;
               end
            end else if (c == CH_COMMA) begin
               if (!mdl_slot_filled) new_err = ERR_EMPTY_SLOT;
               else mdl_slot_filled = 1'b0;
            end else if (c == CH_RBRACE) begin
               if (!last) new_err = ERR_BRACE_EARLY;
            end else if (c != CH_SPACE) begin
               new_err = ERR_BAD_CHAR;
            end
         end
         if (new_err == ERR_NONE && last && c != CH_RBRACE) new_err = ERR_NO_CLOSE;
         if (new_err != ERR_NONE) begin
            mdl_err        = new_err;
            r.value_valid  = 1'b0;
            r.value        = '0;
            r.wildcard_res = 1'b0;
         end
      end else begin
         mdl_at_start = 1'b0;
      end
      r.done_res = last;
      r.error    = last ? mdl_err : ERR_NONE;
      if (last) begin
         mdl_at_start    = 1'b1;
         mdl_in_number   = 1'b0;
         mdl_acc         = 0;
         mdl_slot_filled = 1'b0;
         mdl_err         = ERR_NONE;
      end
      return r;
   endfunction

   function automatic void report_mismatch(input string what, input longint unsigned want_v,
                                           input longint unsigned got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
   endfunction

   task automatic check_result();
      result_type want;
      result_type got;
      got.value_valid  = rsp_if.value_valid;
      got.value        = rsp_if.value;
      got.wildcard_res = rsp_if.wildcard_res;
      got.done_res     = rsp_if.done_res;
      got.error        = rsp_if.error;
      if (due_results.size() == 0) begin
         report_mismatch("result word with none pending", 64'd0, 64'd1);
      end else begin
         want = due_results.pop_front();
         if (got.value_valid !== want.value_valid)
            report_mismatch("value_valid", 64'(want.value_valid), 64'(got.value_valid));
         if (got.value !== want.value)
            report_mismatch("value", 64'(want.value), 64'(got.value));
         if (got.wildcard_res !== want.wildcard_res)
            report_mismatch("wildcard_res", 64'(want.wildcard_res), 64'(got.wildcard_res));
         if (got.done_res !== want.done_res)
            report_mismatch("done_res", 64'(want.done_res), 64'(got.done_res));
         if (got.error !== want.error)
            report_mismatch("error", 64'(want.error), 64'(got.error));
      end
   endtask

   // result side: check, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (rsp_hold_req != 0) begin
            rsp_wait_left = rsp_hold_req;
            rsp_hold_req  = 0;
         end else if (rsp_wait_left == 0 && idling && $urandom_range(0, 5) == 0) begin
            rsp_wait_left = $urandom_range(1, 9);
         end
         if (rsp_wait_left != 0) begin
            rsp_wait_left = rsp_wait_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic void add_char(input logic [CHAR_W-1:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_in   <= ch;
      req_if.last_char <= is_last;
      do begin
         @(posedge clock);
      end while (req_if.ready !== 1'b1);
      due_results.insert(due_results.size(), parse_char(ch, is_last));
      chars_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_char(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      send_line();
   endtask

   function automatic void add_spaces();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) add_char(CH_SPACE);
   endfunction

   function automatic void add_number();
      longint unsigned   num;
      logic [CHAR_W-1:0] digits[$];
      logic [CHAR_W-1:0] d;
      case ($urandom_range(0, 4))
         0:       num = $urandom_range(0, 9);
         1:       num = $urandom_range(0, 99999);
         2:       num = {32'd0, $urandom} & VALUE_LIMIT;
         // straddles the largest value
         3:       num = VALUE_LIMIT - 8 + $urandom_range(0, 16);
         default: num = {$urandom_range(0, 999), $urandom};
      endcase
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) add_char(CH_ZERO);
      do begin
         d = CH_ZERO + CHAR_W'(num % RADIX);
         digits.push_front(d);
         num = num / RADIX;
      end while (num != 0);
      foreach (digits[i]) add_char(digits[i]);
   endfunction

   function automatic logic [CHAR_W-1:0] syntax_char();
      case ($urandom_range(0, 5))
         0:       return CH_COMMA;
         1:       return CH_SPACE;
         2:       return CH_STAR;
         3:       return CH_LBRACE;
         4:       return CH_RBRACE;
         default: return CH_ZERO + CHAR_W'($urandom_range(0, 9));
      endcase
   endfunction

   // well-formed list, then maybe broken in one of several ways
   task automatic build_list();
      int n_elems;
      int pick;
      int cut;
      n_elems = $urandom_range(0, 5);
      line_buf.delete();
      add_char(CH_LBRACE);
      add_spaces();
      for (int k = 0; k < n_elems; k++) begin
         if ($urandom_range(0, 4) == 0) add_char(CH_STAR);
         else add_number();
         add_spaces();
         // trailing comma before the close is legal
         if (k < n_elems - 1 || $urandom_range(0, 7) == 0) begin
            add_char(CH_COMMA);
            add_spaces();
         end
      end
      add_char(CH_RBRACE);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
      end else if (pick < 80) begin
         line_buf[$urandom_range(0, line_buf.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end else if (pick < 88) begin
         cut = $urandom_range(1, line_buf.size());
         while (line_buf.size() > cut) void'(line_buf.pop_back());
      end else if (pick < 94) begin
         line_buf[$urandom_range(0, line_buf.size() - 1)] = syntax_char();
      end else begin
         line_buf.delete();
         if ($urandom_range(0, 1) == 0) add_char(CH_LBRACE);
         repeat ($urandom_range(1, 6)) add_char(CHAR_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_lists(input int n_chars);
      int stop_at;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) begin
         build_list();
         send_line();
      end
   endtask

   task automatic test_directed_errors();
      send_text("{12, *,7 }");
      send_text("{}");
      send_text("{1,}");
      send_text("x");
      send_text("}");
      send_text("{");
      send_text("{a");
      send_text("{{}");
      send_text("{1 2}");
      send_text("{**}");
      send_text("{1*}");
      send_text("{,}");
      send_text("{}}");
      send_text("{1,");
   endtask

   task automatic test_value_extremes();
      send_text("{0,2147483647}");
      send_text("{2147483648}");
      send_text("{0000000000009}");
      line_buf = '{CH_LBRACE, 8'hFF, CH_RBRACE};
      send_line();
      line_buf = '{8'h00};
      send_line();
   endtask

   task automatic test_random_lists();
      idling = 1'b1;
      send_random_lists(1100);
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_output_stall();
      idling       = 1'b0;
      rsp_hold_req = 200;
      send_random_lists(100);
   endtask

   task automatic test_full_rate();
      idling = 1'b0;
      send_random_lists(250);
   endtask

   initial begin
      req_if.valid     <= 1'b0;
      req_if.char_in   <= '0;
      req_if.last_char <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_errors();
      test_value_extremes();
      test_random_lists();
      test_output_stall();
      test_full_rate();
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS brace_index_list_parser_unit");
      end else begin
         $display("FAIL brace_index_list_parser_unit");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL brace_index_list_parser_unit");
      $finish;
   end

endmodule
